// File: hw/rtl/npc_pkg.sv
// Shared types, codes and constants of the nucleotide pattern counter.
package npc_pkg;

  localparam int COUNT_WIDTH  = 32;
  localparam int OUT_W        = 32;
  localparam int BASE_TALLY_W = 7;
  localparam int PAIR_TALLY_W = 11;

  // All totals live in one memory: triples first, then pairs, bases, bad symbols.
  localparam int TOTALS_DEPTH = 85;
  localparam int ADDR_W       = $clog2(TOTALS_DEPTH);
  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t ADDR_PAIR0 = addr_t'(64);
  localparam addr_t ADDR_BASE0 = addr_t'(80);
  localparam addr_t ADDR_BAD   = addr_t'(84);

  typedef enum logic [1:0] {
    KIND_SYMBOL   = 2'd0,
    KIND_READ     = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_RESERVED = 2'd3
  } kind_t;

  localparam logic [1:0] SEL_SINGLE = 2'd0;
  localparam logic [1:0] SEL_PAIR   = 2'd1;
  localparam logic [1:0] SEL_TRIPLE = 2'd2;
  localparam logic [1:0] SEL_BAD    = 2'd3;

  // Update steps of one symbol: sixteen triples, four pairs, the base, or the bad count.
  typedef logic [4:0] step_t;
  localparam step_t STEP_FIRST = step_t'(0);
  localparam step_t STEP_PAIR0 = step_t'(16);
  localparam step_t STEP_BASE  = step_t'(20);
  localparam step_t STEP_BAD   = step_t'(21);

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  symbol_code;
    logic        is_gap;
    logic        last_in_column;
    logic [1:0]  table_select;
    logic [5:0]  counter_index;
  } item_t;

  typedef struct packed {
    logic  ready;
    logic  capture;
    logic  issue;
    step_t step;
    logic  clr_wr;
    addr_t clr_addr;
    logic  clr_tally;
    logic  rd_issue;
    logic  load_out;
    logic  end_col;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  gap;
    logic  bad;
    logic  last;
    logic  out_free;
  } ctl_status_t;

endpackage

// File: hw/rtl/npc_ifs.sv
// Handshake interfaces for the item and result channels.
interface npc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] symbol_code;
  logic       is_gap;
  logic       last_in_column;
  logic [1:0] table_select;
  logic [5:0] counter_index;

  modport source (
    output valid, kind, symbol_code, is_gap, last_in_column, table_select, counter_index,
    input  ready
  );
  modport sink (
    input  valid, kind, symbol_code, is_gap, last_in_column, table_select, counter_index,
    output ready
  );
endinterface

interface npc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] count_value;
  logic        bad_index;

  modport source (output valid, count_value, bad_index, input ready);
  modport sink (input valid, count_value, bad_index, output ready);
endinterface

// File: hw/rtl/npc_ram.sv
// Generic single-write, single-read memory with registered read data.
module npc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/npc_datapath.sv
// Datapath: column tallies, the totals memory with its saturating adder, and the result register.
module npc_datapath #(
  parameter int COUNT_WIDTH = npc_pkg::COUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  npc_pkg::ctl_cmd_t         cmd,
  output npc_pkg::ctl_status_t      st,
  input  npc_pkg::item_t            item_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [npc_pkg::OUT_W-1:0] count_value,
  output logic                      bad_index
);

  npc_pkg::item_t cur;

  logic [npc_pkg::BASE_TALLY_W-1:0] base_tally [4];
  logic [npc_pkg::PAIR_TALLY_W-1:0] pair_tally [16];

  logic                             wr_pend;
  npc_pkg::addr_t                   wr_addr;
  logic [npc_pkg::PAIR_TALLY_W-1:0] wr_addend;

  logic                             base_ok;
  logic [1:0]                       b;
  logic [1:0]                       a;
  logic [3:0]                       k;
  logic                             is_pair_step;
  logic                             is_base_step;
  npc_pkg::addr_t                   step_addr;
  logic [npc_pkg::PAIR_TALLY_W-1:0] step_addend;
  logic [npc_pkg::PAIR_TALLY_W:0]   pair_sum;
  npc_pkg::addr_t                   read_addr;
  logic                             index_bad;

  logic                   ram_we;
  npc_pkg::addr_t         ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  npc_pkg::addr_t         ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_sum;

  // One-hot decode of the latched symbol.
  always_comb begin
    base_ok = 1'b1;
    b       = 2'd0;
    case (cur.symbol_code)
      4'b0001: b = 2'd0;
      4'b0010: b = 2'd1;
      4'b0100: b = 2'd2;
      4'b1000: b = 2'd3;
      default: base_ok = 1'b0;
    endcase
  end

  assign k            = cmd.step[3:0];
  assign a            = cmd.step[1:0];
  assign is_pair_step = (cmd.step >= npc_pkg::STEP_PAIR0) && (cmd.step < npc_pkg::STEP_BASE);
  assign is_base_step = (cmd.step == npc_pkg::STEP_BASE);
  assign pair_sum     = {1'b0, pair_tally[{a, b}]} + (npc_pkg::PAIR_TALLY_W + 1)'(base_tally[a]);

  always_comb begin
    if (cmd.step < npc_pkg::STEP_PAIR0) begin
      step_addr   = npc_pkg::addr_t'({k, b});
      step_addend = pair_tally[k];
    end else if (is_pair_step) begin
      step_addr   = npc_pkg::ADDR_PAIR0 + npc_pkg::addr_t'({a, b});
      step_addend = npc_pkg::PAIR_TALLY_W'(base_tally[a]);
    end else if (is_base_step) begin
      step_addr   = npc_pkg::ADDR_BASE0 + npc_pkg::addr_t'(b);
      step_addend = npc_pkg::PAIR_TALLY_W'(1);
    end else begin
      step_addr   = npc_pkg::ADDR_BAD;
      step_addend = npc_pkg::PAIR_TALLY_W'(1);
    end
  end

  always_comb begin
    case (cur.table_select)
      npc_pkg::SEL_SINGLE: begin
        read_addr = npc_pkg::ADDR_BASE0 + npc_pkg::addr_t'(cur.counter_index[1:0]);
        index_bad = (cur.counter_index[5:2] != 4'd0);
      end
      npc_pkg::SEL_PAIR: begin
        read_addr = npc_pkg::ADDR_PAIR0 + npc_pkg::addr_t'(cur.counter_index[3:0]);
        index_bad = (cur.counter_index[5:4] != 2'd0);
      end
      npc_pkg::SEL_TRIPLE: begin
        read_addr = npc_pkg::addr_t'(cur.counter_index);
        index_bad = 1'b0;
      end
      default: begin
        read_addr = npc_pkg::ADDR_BAD;
        index_bad = (cur.counter_index != 6'd0);
      end
    endcase
  end

  // Read in the issue cycle, add and write back in the next one.
  assign sum       = {1'b0, ram_rdata} + (COUNT_WIDTH + 1)'(wr_addend);
  assign sat_sum   = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  assign ram_we    = cmd.clr_wr | wr_pend;
  assign ram_waddr = cmd.clr_wr ? cmd.clr_addr : wr_addr;
  assign ram_wdata = cmd.clr_wr ? '0 : sat_sum;
  assign ram_re    = cmd.issue | cmd.rd_issue;
  assign ram_raddr = cmd.rd_issue ? read_addr : step_addr;

  npc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (npc_pkg::TOTALS_DEPTH)
  ) u_totals (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item_data;
    end
    wr_addr   <= step_addr;
    wr_addend <= step_addend;
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_tally || cmd.end_col) begin
      for (int i = 0; i < 4; i++) begin
        base_tally[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        pair_tally[i] <= '0;
      end
    end else if (cmd.issue) begin
      if (is_pair_step) begin
        pair_tally[{a, b}] <= pair_sum[npc_pkg::PAIR_TALLY_W] ? '1
                                : pair_sum[npc_pkg::PAIR_TALLY_W-1:0];
      end
      if (is_base_step && (base_tally[b] != '1)) begin
        base_tally[b] <= base_tally[b] + npc_pkg::BASE_TALLY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
    if (cmd.load_out) begin
      count_value <= index_bad ? '0 : npc_pkg::OUT_W'(ram_rdata);
      bad_index   <= index_bad;
    end
  end

  assign st.kind     = cur.kind;
  assign st.gap      = cur.is_gap;
  assign st.bad      = ~base_ok;
  assign st.last     = cur.last_in_column;
  assign st.out_free = ~out_valid | out_ready;

endmodule

// File: hw/rtl/npc_controller.sv
// Controller: sequences clearing sweeps, symbol update steps and counter reads.
module npc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  npc_pkg::ctl_status_t st,
  output npc_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_UPDATE,
    S_DRAIN,
    S_READ_WAIT
  } state_t;

  state_t          state;
  npc_pkg::step_t  step;
  npc_pkg::addr_t  clr_cnt;

  always_comb begin
    cmd           = '0;
    cmd.step      = step;
    cmd.clr_addr  = clr_cnt;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        cmd.clr_tally = 1'b1;
      end
      S_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        cmd.rd_issue = (st.kind == npc_pkg::KIND_READ);
        cmd.end_col  = (st.kind == npc_pkg::KIND_SYMBOL) && st.gap && st.last;
      end
      S_UPDATE: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
        cmd.end_col = st.last;
      end
      S_READ_WAIT: begin
        cmd.load_out = st.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      step    <= npc_pkg::STEP_FIRST;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_cnt == npc_pkg::addr_t'(npc_pkg::TOTALS_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + npc_pkg::addr_t'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (st.kind)
            npc_pkg::KIND_SYMBOL: begin
              if (st.gap) begin
                state <= S_IDLE;
              end else begin
                step  <= st.bad ? npc_pkg::STEP_BAD : npc_pkg::STEP_FIRST;
                state <= S_UPDATE;
              end
            end
            npc_pkg::KIND_READ: state <= S_READ_WAIT;
            npc_pkg::KIND_CLEAR: begin
              clr_cnt <= '0;
              state   <= S_CLEAR;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_UPDATE: begin
          if ((step == npc_pkg::STEP_BASE) || (step == npc_pkg::STEP_BAD)) begin
            state <= S_DRAIN;
          end else begin
            step <= step + npc_pkg::step_t'(1);
          end
        end
        S_DRAIN: state <= S_IDLE;
        S_READ_WAIT: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/nucleotide_pattern_counter.sv
// Top level of the nucleotide pattern counter: controller, datapath and assertions.
//
// The block takes one item per beat on the item channel and builds histograms of single
// bases, ordered base pairs and ordered base triples over the columns of an alignment.
// Symbol beats are taken one taxon at a time; a set last_in_column closes the column. Gaps
// are skipped and codes that are not one-hot only bump the bad-symbol count. Every total
// saturates at its maximum. A read beat returns one counter (zero with bad_index set when
// the index is out of range for the table) as one beat on the result channel; symbol,
// clear and reserved beats return nothing. All totals sit in one memory with a single
// read port and a single write port, and every update is a read, a saturating add and a
// write-back through one adder, overlapped so one update issues each cycle. A valid base
// passes the accept, decode and drain states around twenty-one updates (sixteen triples,
// four pairs and the base), a bad code the same states around one update of the bad
// count, a gap only accept and decode, and a read accept, decode and read-wait, where it
// stays while an earlier result still waits. A clear beat, and also the release of reset,
// runs a sweep that zeroes all 85 entries of the totals memory one entry per cycle; ready
// stays low during the sweep. Items are processed one at a time, but a new item is taken
// while a finished result still waits in the output register.
module nucleotide_pattern_counter #(
  parameter int COUNT_WIDTH = npc_pkg::COUNT_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  npc_item_if.sink      item,
  npc_result_if.source  result
);

  npc_pkg::ctl_cmd_t    cmd;
  npc_pkg::ctl_status_t st;
  npc_pkg::item_t       item_data;

  // Gather the item fields into one word for the datapath.
  assign item_data.kind           = npc_pkg::kind_t'(item.kind);
  assign item_data.symbol_code    = item.symbol_code;
  assign item_data.is_gap         = item.is_gap;
  assign item_data.last_in_column = item.last_in_column;
  assign item_data.table_select   = item.table_select;
  assign item_data.counter_index  = item.counter_index;

  // The controller is ready only between items, so each beat is decoded before the next.
  assign item.ready = cmd.ready;

  npc_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .st       (st),
    .cmd      (cmd)
  );

  npc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .item_data   (item_data),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .count_value (result.count_value),
    .bad_index   (result.bad_index)
  );

`ifndef SYNTHESIS
  // A result beat appears only because the controller loaded the output register.
  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.load_out))
    else $error("result valid rose without an output load");

  // A memory read for a read beat is followed by a load or by a stall on a full output.
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> (cmd.load_out || !st.out_free))
    else $error("read data was neither loaded nor held for a full output");

  // While waiting for an item, no update or clearing write is in flight.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> (!cmd.issue && !cmd.clr_wr && !$past(cmd.issue)))
    else $error("memory update still in flight while ready");

  // Closing a column never coincides with an update step that reads the tallies.
  a_endcol_apart: assert property (@(posedge clk) disable iff (rst)
    cmd.end_col |-> !cmd.issue)
    else $error("column tallies cleared during an update step");
`endif

endmodule
